// ----- design/linear_ucb_ridge_model_core_macros.svh -----
// Assertion helpers for the ridge model core.
`ifndef LINEAR_UCB_RIDGE_MODEL_CORE_MACROS_SVH
`define LINEAR_UCB_RIDGE_MODEL_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define LUCB_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lucb check failed");
// Check a property on every clock edge, reset included
`define LUCB_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("lucb reset check failed");
`else
`define LUCB_ASSERT(label, prop)
`define LUCB_ASSERT_RST(label, prop)
`endif
`endif

// ----- design/lucb_pkg.sv -----
`default_nettype none
package lucb_pkg;

   localparam int FEATURES_DEF = 14;
   localparam int FRAC_BITS    = 24;
   localparam logic [30:0] DIAG_RESET = 31'd16777216;

   // Opcodes carried in tuser
   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_ESTIMATE = 2'd1;
   localparam logic [1:0] OP_UPDATE   = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   // Register index of the diagonal value (paddr bit 2)
   localparam logic REG_DIAG = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_MUL,
      ST_ACC,
      ST_ROOT,
      ST_DD_ROW,
      ST_DD_ISSUE,
      ST_DD_MUL,
      ST_DD_PREP,
      ST_DD_DIV,
      ST_DD_WB,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_PRED,
      PH_MV,
      PH_QUAD,
      PH_TGT,
      PH_COEF
   } phase_type;

endpackage
`default_nettype wire

// ----- design/linear_ucb_ridge_model_core.sv -----
// Estimate: prediction, Gram-vector product, quadratic form and square root follow the last element;
//   update adds a Gram downdate, using the 1-bit-per-cycle divider, then the target and coefficient phases.
// Throughput: one element per cycle while collecting; one vector at a time after that.
// Single shared 32x32 multiplier; one Gram memory port (read or write per cycle).
// Reset is synchronous: it starts a clearing pass of the Gram memory,
//   during which req_tready stays low; a clear opcode runs the same pass.
`default_nettype none
`include "linear_ucb_ridge_model_core_macros.svh"
module linear_ucb_ridge_model_core #(
   parameter int FEATURES = lucb_pkg::FEATURES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] feature_value, [63:32] target
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   input  logic        req_tlast,   // last_feature
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] prediction, [62:32] uncertainty, [63] saturated
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lucb_pkg::*;

   localparam int IW    = $clog2(FEATURES);
   localparam int CW    = $clog2(FEATURES + 1);
   localparam int DEPTH = FEATURES * FEATURES;
   localparam int MW    = $clog2(DEPTH);
   localparam int ACC_W = 41 + $clog2(FEATURES);
   localparam logic [IW-1:0] LAST_IDX  = IW'(FEATURES - 1);
   localparam logic [MW-1:0] LAST_ADDR = MW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(FEATURES);
   localparam logic [55:0]   SQ_TOP    = 56'd1 << 54;
   localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(64'sh7FFFFFFF);
   localparam logic signed [ACC_W-1:0] MIN32 = -ACC_W'(64'sh80000000);
   localparam logic signed [ACC_W:0]   ONE_Q = (ACC_W+1)'(64'sd16777216);

   // Control and sequencing
   state_type state_ff, state_in;
   phase_type phase_ff;
   logic [1:0]    op_ff;
   logic [CW-1:0] cnt_ff, nvalid_ff;
   logic [IW-1:0] row_ff, col_ff;
   logic [MW-1:0] addr_ff;
   logic [30:0]   diag_ff, sweep_diag_ff;

   // Vector stores and datapath registers
   logic signed [31:0] fb_ff   [FEATURES];
   logic signed [31:0] pv_ff   [FEATURES];
   logic signed [31:0] bs_ff   [FEATURES];
   logic signed [31:0] wv_ff   [FEATURES];
   logic signed [31:0] gram_mem[DEPTH];
   logic signed [31:0] rdata_ff, opa_ff, opb_ff, tgt_ff, pred_ff, d_ff, prow_ff, a_old_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff, quad_ff;
   logic [30:0] unc_ff;
   logic        sat_ff;
   logic [55:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [62:0] div_q_ff;
   logic [31:0] div_rem_ff;
   logic [5:0]  div_cnt_ff;
   logic        div_neg_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;

   // Combinational signals
   logic               req_acc, mem_we, out_load, mem_phase;
   logic signed [31:0] mem_wdata, x_col, mul_a;
   logic [IW-1:0]      pv_idx;
   logic signed [63:0] rnd_full;
   logic signed [ACC_W-1:0] sum, start;
   logic signed [31:0] sum_sat;
   logic               sum_clip, row_end, phase_end, sq_ge, sq_done;
   logic [55:0]        sq_trial;
   logic signed [ACC_W:0] d_sum;
   logic signed [31:0] d_sat;
   logic               d_clip;
   logic [31:0]        rem_sh;
   logic               rem_ge;
   logic [63:0]        prod_mag;
   logic signed [64:0] a_ext, q_ext, wb_diff;
   logic signed [31:0] wb_sat;
   logic               wb_clip;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_DIAG) ? {1'b0, diag_ff} : 32'd0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign req_acc    = req_tvalid && req_tready;

   // Operand selection and shared arithmetic
   assign mem_phase = (phase_ff == PH_MV) || (phase_ff == PH_COEF);
   assign x_col     = (CW'(col_ff) < nvalid_ff) ? fb_ff[col_ff] : 32'sd0;
   assign mul_a     = (state_ff == ST_MUL && mem_phase) ? rdata_ff : opa_ff;
   assign rnd_full  = (prod_ff + 64'sd8388608) >>> FRAC_BITS;
   assign start     = (phase_ff == PH_TGT) ? ACC_W'(bs_ff[col_ff]) :
                      ((col_ff == '0) ? '0 : acc_ff);
   assign sum       = start + ACC_W'(signed'(rnd_full[39:0]));
   assign sum_clip  = (sum > MAX32) || (sum < MIN32);
   assign sum_sat   = (sum > MAX32) ? 32'sh7FFFFFFF :
                      (sum < MIN32) ? 32'sh80000000 : sum[31:0];
   assign row_end   = (phase_ff == PH_TGT) || (col_ff == LAST_IDX);
   assign phase_end = mem_phase ? (row_ff == LAST_IDX && col_ff == LAST_IDX)
                                : (col_ff == LAST_IDX);

   // Square root step
   assign sq_trial = sq_res_ff + sq_bit_ff;
   assign sq_ge    = sq_v_ff >= sq_trial;
   assign sq_done  = sq_bit_ff[0];

   // Denominator of the downdate
   assign d_sum  = ONE_Q + (ACC_W+1)'(quad_ff);
   assign d_clip = (d_sum > (ACC_W+1)'(MAX32)) || (d_sum < (ACC_W+1)'(MIN32));
   assign d_sat  = (d_sum > (ACC_W+1)'(MAX32)) ? 32'sh7FFFFFFF :
                   (d_sum < (ACC_W+1)'(MIN32)) ? 32'sh80000000 : d_sum[31:0];

   // Divider step and write-back
   assign rem_sh   = {div_rem_ff[30:0], div_q_ff[62]};
   assign rem_ge   = rem_sh >= 32'(d_ff);
   assign prod_mag = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
   assign a_ext    = 65'(a_old_ff);
   assign q_ext    = {2'b00, div_q_ff};
   assign wb_diff  = div_neg_ff ? (a_ext + q_ext) : (a_ext - q_ext);
   assign wb_clip  = (wb_diff > 65'sh7FFFFFFF) || (wb_diff < -65'sh80000000);
   assign wb_sat   = (wb_diff > 65'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                     (wb_diff < -65'sh80000000) ? 32'sh80000000 : wb_diff[31:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if ((req_tuser == OP_ESTIMATE || req_tuser == OP_UPDATE) && req_tlast) begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            if (phase_end && phase_ff == PH_QUAD) state_in = ST_ROOT;
            else if (phase_end && phase_ff == PH_COEF) state_in = ST_DONE;
            else state_in = ST_ISSUE;
         end
         ST_ROOT: begin
            if (sq_done) begin
               if (op_ff != OP_UPDATE) state_in = ST_DONE;
               else if (d_sat > 32'sd0) state_in = ST_DD_ROW;
               else state_in = ST_ISSUE;
            end
         end
         ST_DD_ROW:   state_in = ST_DD_ISSUE;
         ST_DD_ISSUE: state_in = ST_DD_MUL;
         ST_DD_MUL:   state_in = ST_DD_PREP;
         ST_DD_PREP:  state_in = ST_DD_DIV;
         ST_DD_DIV: begin
            if (div_cnt_ff == 6'd62) state_in = ST_DD_WB;
         end
         ST_DD_WB: begin
            if (col_ff != LAST_IDX) state_in = ST_DD_ISSUE;
            else if (row_ff != LAST_IDX) state_in = ST_DD_ROW;
            else state_in = ST_ISSUE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_wdata  = wb_sat;
      pv_idx     = col_ff;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = (row_ff == col_ff) ? {1'b0, sweep_diag_ff} : 32'sd0;
         end
         ST_IDLE:   req_tready = 1'b1;
         ST_DD_ROW: pv_idx = row_ff;
         ST_DD_WB:  mem_we = 1'b1;
         ST_DONE:   out_load = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   // Gram memory: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) gram_mem[addr_ff] <= mem_wdata;
      rdata_ff <= gram_mem[addr_ff];
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         diag_ff <= DIAG_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_DIAG) begin
         diag_ff <= csr_pwdata[30:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) rsp_data_ff <= {sat_ff, unc_ff, pred_ff};
   end

   // Sequencer state and datapath
   always_ff @(posedge clock) begin
      // Reset starts the clearing pass with the default diagonal
      if (reset) begin
         state_ff      <= ST_CLEAR;
         phase_ff      <= PH_PRED;
         sweep_diag_ff <= DIAG_RESET;
         addr_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         cnt_ff        <= '0;
         nvalid_ff     <= '0;
         op_ff         <= OP_CLEAR;
         sat_ff        <= 1'b0;
         for (int i = 0; i < FEATURES; i++) begin
            bs_ff[i] <= 32'sd0;
            wv_ff[i] <= 32'sd0;
         end
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_CLEAR: begin
               addr_ff <= (addr_ff == LAST_ADDR) ? '0 : addr_ff + MW'(1);
               if (col_ff == LAST_IDX) begin
                  col_ff <= '0;
                  row_ff <= row_ff + IW'(1);
               end else begin
                  col_ff <= col_ff + IW'(1);
               end
            end
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_tuser == OP_CLEAR) begin
                     sweep_diag_ff <= diag_ff;
                     addr_ff <= '0;
                     row_ff  <= '0;
                     col_ff  <= '0;
                     cnt_ff  <= '0;
                     for (int i = 0; i < FEATURES; i++) begin
                        bs_ff[i] <= 32'sd0;
                        wv_ff[i] <= 32'sd0;
                     end
                  end else if (req_tuser == OP_ESTIMATE || req_tuser == OP_UPDATE) begin
                     if (cnt_ff < FULL_CNT) fb_ff[cnt_ff[IW-1:0]] <= req_tdata[31:0];
                     if (req_tlast) begin
                        nvalid_ff <= (cnt_ff < FULL_CNT) ? cnt_ff + CW'(1) : cnt_ff;
                        cnt_ff    <= '0;
                        op_ff     <= req_tuser;
                        tgt_ff    <= req_tdata[63:32];
                        sat_ff    <= 1'b0;
                        phase_ff  <= PH_PRED;
                        row_ff    <= '0;
                        col_ff    <= '0;
                        addr_ff   <= '0;
                     end else if (cnt_ff < FULL_CNT) begin
                        cnt_ff <= cnt_ff + CW'(1);
                     end
                  end
               end
            end
            ST_ISSUE: begin
               case (phase_ff)
                  PH_PRED: begin
                     opa_ff <= wv_ff[col_ff];
                     opb_ff <= x_col;
                  end
                  PH_QUAD: begin
                     opa_ff <= x_col;
                     opb_ff <= pv_ff[pv_idx];
                  end
                  PH_TGT: begin
                     opa_ff <= x_col;
                     opb_ff <= tgt_ff;
                  end
                  PH_COEF: opb_ff <= bs_ff[col_ff];
                  default: opb_ff <= x_col;
               endcase
            end
            ST_MUL: prod_ff <= mul_a * opb_ff;
            ST_ACC: begin
               acc_ff <= sum;
               if (row_end) begin
                  if (sum_clip) sat_ff <= 1'b1;
                  case (phase_ff)
                     PH_PRED: pred_ff <= sum_sat;
                     PH_MV:   pv_ff[row_ff] <= sum_sat;
                     PH_QUAD: quad_ff <= sum;
                     PH_TGT:  bs_ff[col_ff] <= sum_sat;
                     default: wv_ff[row_ff] <= sum_sat;
                  endcase
               end
               if (phase_end) begin
                  row_ff  <= '0;
                  col_ff  <= '0;
                  addr_ff <= '0;
                  case (phase_ff)
                     PH_PRED: phase_ff <= PH_MV;
                     PH_MV:   phase_ff <= PH_QUAD;
                     PH_TGT:  phase_ff <= PH_COEF;
                     default: phase_ff <= phase_ff;
                  endcase
                  // Load the root unit from the clipped quadratic form
                  if (phase_ff == PH_QUAD) begin
                     sq_v_ff   <= (sum_sat > 32'sd0) ? {1'b0, sum_sat[30:0], 24'd0} : 56'd0;
                     sq_res_ff <= '0;
                     sq_bit_ff <= SQ_TOP;
                  end
               end else begin
                  addr_ff <= addr_ff + MW'(1);
                  if (mem_phase && col_ff == LAST_IDX) begin
                     col_ff <= '0;
                     row_ff <= row_ff + IW'(1);
                  end else begin
                     col_ff <= col_ff + IW'(1);
                  end
               end
            end
            ST_ROOT: begin
               if (sq_ge) begin
                  sq_v_ff   <= sq_v_ff - sq_trial;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               if (sq_done) begin
                  unc_ff <= sq_ge ? sq_res_ff[31:1] + 31'd1 : sq_res_ff[31:1];
                  if (op_ff == OP_UPDATE) begin
                     d_ff <= d_sat;
                     if (d_clip || d_sat <= 32'sd0) sat_ff <= 1'b1;
                     if (d_sat <= 32'sd0) phase_ff <= PH_TGT;
                  end
               end
            end
            ST_DD_ROW: prow_ff <= pv_ff[pv_idx];
            ST_DD_ISSUE: begin
               opa_ff <= prow_ff;
               opb_ff <= pv_ff[pv_idx];
            end
            ST_DD_MUL: begin
               prod_ff  <= mul_a * opb_ff;
               a_old_ff <= rdata_ff;
            end
            ST_DD_PREP: begin
               div_q_ff   <= prod_mag[62:0] + 63'(d_ff[30:1]);
               div_neg_ff <= prod_ff[63];
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
            end
            ST_DD_DIV: begin
               div_rem_ff <= rem_ge ? rem_sh - 32'(d_ff) : rem_sh;
               div_q_ff   <= {div_q_ff[61:0], rem_ge};
               div_cnt_ff <= div_cnt_ff + 6'd1;
            end
            ST_DD_WB: begin
               if (wb_clip) sat_ff <= 1'b1;
               if (col_ff == LAST_IDX) begin
                  col_ff <= '0;
                  if (row_ff == LAST_IDX) begin
                     row_ff   <= '0;
                     addr_ff  <= '0;
                     phase_ff <= PH_TGT;
                  end else begin
                     row_ff  <= row_ff + IW'(1);
                     addr_ff <= addr_ff + MW'(1);
                  end
               end else begin
                  col_ff  <= col_ff + IW'(1);
                  addr_ff <= addr_ff + MW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   `LUCB_ASSERT(a_cnt_range, cnt_ff <= FULL_CNT)
   `LUCB_ASSERT(a_addr_range, addr_ff <= LAST_ADDR)
   `LUCB_ASSERT(a_dd_denom_pos, state_ff == ST_DD_ISSUE |-> d_ff > 32'sd0)
   `LUCB_ASSERT_RST(a_reset_sweep, reset |=> !req_tready)

endmodule
`default_nettype wire
